// ----- src/cpu_load_bar_meter_defines.svh -----
// assertion macros for the cpu load bar meter
// no dependencies
`ifndef CPU_LOAD_BAR_METER_DEFINES_SVH
`define CPU_LOAD_BAR_METER_DEFINES_SVH
`ifndef SYNTHESIS
`define CLB_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CLB_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CLB_ASSERT(label, clk, rst, prop, msg)
`define CLB_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ----- src/clbm_pkg.sv -----
// shared types and constants of the cpu load bar meter
// no dependencies
package clbm_pkg;
  localparam int TASK_SLOTS_DEF  = 6;
  localparam int BAR_COLUMNS_DEF = 12;
  localparam int TICK_W = 32;
  localparam int PCT_W  = 7;
  localparam int ROW_W  = 12;
  localparam int NUM_INPUTS = 6;

  typedef struct packed {
    logic [31:0] total_ticks;
    logic [2:0]  task_count;
    logic [31:0] idle_ticks;
    logic [31:0] task1_ticks;
    logic [31:0] task2_ticks;
    logic [31:0] task3_ticks;
    logic [31:0] task4_ticks;
    logic [31:0] task5_ticks;
  } in_item_t;

  typedef struct packed {
    logic [11:0] row_0;
    logic [11:0] row_1;
    logic [11:0] row_2;
    logic [11:0] row_3;
    logic [11:0] row_4;
    logic [11:0] row_5;
    logic [11:0] row_6;
    logic [11:0] row_7;
    logic [6:0]  load_out;
    logic [31:0] samples_done;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic enable;
  } lane_ctl_t;
endpackage

// ----- src/clbm_lane.sv -----
// one percent lane: bit-serial restoring division of delta*100 by total delta
// depends on clbm_pkg
module clbm_lane (
  input  logic                          clk,
  input  clbm_pkg::lane_ctl_t           ctl,
  input  logic [clbm_pkg::TICK_W-1:0]   delta,
  input  logic [clbm_pkg::TICK_W-1:0]   divisor,
  output logic [clbm_pkg::PCT_W-1:0]    pct
);
  import clbm_pkg::*;
  localparam int NUM_W = TICK_W + 7;

  logic [NUM_W-1:0] num;
  logic [NUM_W-1:0] quo;
  logic [TICK_W:0]  rem;
  logic [TICK_W-1:0] dsr;
  logic [TICK_W:0]  trial;
  logic             fit;

  // numerator delta*100 = delta*64 + delta*32 + delta*4
  assign trial = {rem[TICK_W-1:0], num[NUM_W-1]};
  assign fit = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      num <= ({7'd0, delta} << 6) + ({7'd0, delta} << 5) + ({7'd0, delta} << 2);
      dsr <= divisor;
      rem <= '0;
      quo <= '0;
    end else if (ctl.enable) begin
      num <= {num[NUM_W-2:0], 1'b0};
      rem <= fit ? (trial - {1'b0, dsr}) : trial;
      quo <= {quo[NUM_W-2:0], fit};
    end
  end

  assign pct = (quo > NUM_W'(100)) ? PCT_W'(100) : quo[PCT_W-1:0];
endmodule

// ----- src/clbm_bar.sv -----
// bar length from percent: ceil(pct*cols/100) clamped, as a low-bit mask
// depends on clbm_pkg
module clbm_bar #(
  parameter int BAR_COLUMNS = clbm_pkg::BAR_COLUMNS_DEF
) (
  input  logic [clbm_pkg::PCT_W-1:0] pct,
  output logic [clbm_pkg::ROW_W-1:0] row
);
  import clbm_pkg::*;
  localparam int PW = PCT_W + 7 + 1;
  logic [PW-1:0] prod;
  logic [PW-1:0] len;
  logic [63:0]   mask;

  always_comb begin
    prod = PW'(pct) * PW'(BAR_COLUMNS) + PW'(99);
    len = '0;
    // small quotient by repeated compare, BAR_COLUMNS steps over constants
    for (int k = 1; k <= BAR_COLUMNS; k++) begin
      if (prod >= PW'(100 * k)) len = PW'(k);
    end
    mask = '0;
    for (int k = 0; k < 64; k++) begin
      mask[k] = (PW'(k) < len);
    end
    row = mask[ROW_W-1:0];
  end
endmodule

// ----- src/cpu_load_bar_meter.sv -----
// cpu load bar meter top level: deltas, six parallel division lanes, merge, frame
// depends on clbm_pkg, clbm_lane, clbm_bar and cpu_load_bar_meter_defines.svh
//
// From transfer in to result valid one sample goes through these steps: the
// deltas are formed, the bit-serial dividers load and take 39 steps (one quotient
// bit per cycle, all task lanes in parallel), then the merge and the output register.
// A new sample is taken once the previous result has been transferred out.
`include "cpu_load_bar_meter_defines.svh"
module cpu_load_bar_meter #(
  parameter int TASK_SLOTS  = clbm_pkg::TASK_SLOTS_DEF,
  parameter int BAR_COLUMNS = clbm_pkg::BAR_COLUMNS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  clbm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output clbm_pkg::out_item_t out_data
);
  import clbm_pkg::*;
  localparam int STEPS = TICK_W + 7;
  localparam int CNT_W = $clog2(STEPS + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_DIV   = 4'b0010,
    S_MERGE = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  state_t state, state_next;
  logic [CNT_W-1:0] cnt;
  logic [TICK_W-1:0] prev_total;
  logic [TICK_W-1:0] prev_task_ticks [TASK_SLOTS];
  logic [PCT_W-1:0]  load_pct;
  logic [PCT_W-1:0]  task_pct [TASK_SLOTS];
  logic [TICK_W-1:0] sample_counter;
  logic [TICK_W-1:0] delta [NUM_INPUTS];
  logic [TICK_W-1:0] d_total;
  logic [2:0]        n_eff;
  logic [PCT_W-1:0]  lane_pct [NUM_INPUTS];
  logic [TICK_W-1:0] in_tick [NUM_INPUTS];
  logic [ROW_W-1:0]  bar_row [NUM_INPUTS];
  logic [PCT_W-1:0]  bar_pct [NUM_INPUTS];
  lane_ctl_t         lctl;
  logic              accept;

  assign in_ready = (state == S_IDLE);
  assign accept = in_valid && in_ready;
  assign in_tick[0] = in_data.idle_ticks;
  assign in_tick[1] = in_data.task1_ticks;
  assign in_tick[2] = in_data.task2_ticks;
  assign in_tick[3] = in_data.task3_ticks;
  assign in_tick[4] = in_data.task4_ticks;
  assign in_tick[5] = in_data.task5_ticks;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept) state_next = S_DIV;
      S_DIV:   if (cnt == CNT_W'(STEPS)) state_next = S_MERGE;
      S_MERGE: state_next = S_OUT;
      S_OUT:   if (out_valid && out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign lctl.start  = (state == S_DIV) && (cnt == '0);
  assign lctl.enable = (state == S_DIV) && (cnt != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      prev_total <= '0;
      load_pct <= '0;
      sample_counter <= '0;
      for (int i = 0; i < TASK_SLOTS; i++) begin
        prev_task_ticks[i] <= '0;
        task_pct[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (accept) begin
        n_eff <= (in_data.task_count > 3'd6) ? 3'd6 : in_data.task_count;
        d_total <= in_data.total_ticks - prev_total;
        prev_total <= in_data.total_ticks;
        cnt <= '0;
        for (int i = 0; i < NUM_INPUTS; i++) begin
          delta[i] <= in_tick[i] - prev_task_ticks[i];
          if (3'(i) < in_data.task_count) prev_task_ticks[i] <= in_tick[i];
        end
      end
      if (state == S_DIV) cnt <= cnt + CNT_W'(1);
      if (state == S_MERGE && d_total != '0) begin
        if (n_eff != 3'd0) load_pct <= PCT_W'(100) - lane_pct[0];
        for (int i = 0; i < NUM_INPUTS; i++) begin
          if (3'(i) < n_eff) task_pct[i] <= lane_pct[i];
        end
        sample_counter <= sample_counter + TICK_W'(1);
      end
    end
  end

  for (genvar g = 0; g < NUM_INPUTS; g++) begin : g_lane
    clbm_lane u_lane (
      .clk(clk), .ctl(lctl),
      .delta(delta[g]), .divisor(d_total), .pct(lane_pct[g])
    );
    assign bar_pct[g] = (g == 0) ? load_pct : task_pct[g];
    clbm_bar #(.BAR_COLUMNS(BAR_COLUMNS)) u_bar (.pct(bar_pct[g]), .row(bar_row[g]));
  end

  // output register, cleared in the merge state and loaded in the out state together with valid
  always_ff @(posedge clk) begin
    if (state == S_MERGE) out_data <= '0;
    if (state == S_OUT && !out_valid) begin
      out_data.row_0 <= bar_row[0];
      out_data.row_1 <= bar_row[0];
      out_data.row_2 <= '0;
      out_data.row_3 <= bar_row[1];
      out_data.row_4 <= bar_row[2];
      out_data.row_5 <= bar_row[3];
      out_data.row_6 <= bar_row[4];
      out_data.row_7 <= bar_row[5];
      out_data.load_out <= load_pct;
      out_data.samples_done <= sample_counter;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (out_valid && out_ready) out_valid <= 1'b0;
    else if (state == S_OUT) out_valid <= 1'b1;
  end

  `CLB_ASSERT(a_no_accept_busy, clk, rst, (state != S_IDLE) |-> !in_ready, "busy but ready")
  `CLB_ASSERT(a_load_range, clk, rst, load_pct <= PCT_W'(100), "load above 100")
  `CLB_ASSERT(a_valid_in_out, clk, rst, out_valid |-> (state == S_OUT), "valid outside out state")
endmodule
